// ===== design/ctb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctb_pkg: shared types and constants of the cursor text buffer
// Holds the beat field widths, the command codes and the sequencer states.
// ----------------------------------------------------------------------------
package ctb_pkg;

  localparam int CMD_W  = 3;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 10;
  localparam int LEN_W  = 11;

  localparam logic [CMD_W-1:0] CMD_LEFT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RIGHT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BACK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

// ===== design/ctb_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctb_ifs: command and result channels of the cursor text buffer
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ctb_in_if import ctb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [CHAR_W-1:0] char_in;
  logic [IDX_W-1:0]  read_index;

  modport source(output valid, command, char_in, read_index, input ready);
  modport sink(input valid, command, char_in, read_index, output ready);
endinterface

interface ctb_out_if import ctb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic [LEN_W-1:0]  text_length;
  logic [LEN_W-1:0]  cursor_pos;
  logic              insert_dropped;
  logic              read_out_of_range;

  modport source(output valid, char_out, text_length, cursor_pos, insert_dropped,
                 read_out_of_range, input ready);
  modport sink(input valid, char_out, text_length, cursor_pos, insert_dropped,
               read_out_of_range, output ready);
endinterface

// ===== design/ctb_text_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctb_text_ram: character store of the gap buffer
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ctb_text_ram import ctb_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CHAR_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [CHAR_W-1:0] rdata
);

  logic [CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/cursor_text_buffer.sv =====
`timescale 1ns / 1ps
// A command accepted in the idle state is held in the command registers, and its result is
// registered as the block leaves the execute state. One command is worked on at a time, as
// each needs a read and write-back pass through the text memory (read issued in the accept
// cycle, write-back and result in the execute state). A result waiting on the output stalls
// only the execute state of the next command. Reset clears the cursor counts and the result
// valid flag; the text memory is not cleared and its entries are undefined until written.
// ----------------------------------------------------------------------------
// cursor_text_buffer: line-edit gap buffer with a cursor
// Text left of the cursor fills the memory from the bottom, text right of it
// fills the memory from the top. Moves copy one character across the gap.
// ----------------------------------------------------------------------------
module cursor_text_buffer import ctb_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  ctb_in_if.sink    in_chan,
  ctb_out_if.source out_chan
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > IDX_W) ? CW : IDX_W) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  state_t state_r, state_nxt;

  logic [CW-1:0]     left_r, left_nxt;
  logic [CW-1:0]     right_r, right_nxt;
  logic [CMD_W-1:0]  cmd_r;
  logic [CHAR_W-1:0] char_r;
  logic [IDX_W-1:0]  idx_r;

  logic              out_valid_r;
  logic [CHAR_W-1:0] char_out_r;
  logic [LEN_W-1:0]  text_length_r;
  logic [LEN_W-1:0]  cursor_pos_r;
  logic              dropped_r;
  logic              oor_r;

  logic              accept;
  logic              adv;
  logic [CW-1:0]     len;
  logic [XW-1:0]     idx_x;
  logic [XW-1:0]     left_x;
  logic [XW-1:0]     right_x;
  logic [AW-1:0]     rd_addr;
  logic [CHAR_W-1:0] rd_data;
  logic              we;
  logic [AW-1:0]     wr_addr;
  logic [CHAR_W-1:0] wr_data;
  logic [CHAR_W-1:0] chr_nxt;
  logic              dropped_nxt;
  logic              oor_nxt;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign adv           = (state_r == ST_EXEC) && (!out_valid_r || out_chan.ready);
  assign len           = left_r + right_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: if (adv) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_chan.command;
      char_r <= in_chan.char_in;
      idx_r  <= in_chan.read_index;
    end
  end

  always_comb begin
    idx_x   = XW'(in_chan.read_index);
    left_x  = XW'(left_r);
    right_x = XW'(right_r);
    rd_addr = '0;
    unique case (in_chan.command)
      CMD_LEFT:  rd_addr = AW'(left_r - CW'(1));
      CMD_RIGHT: rd_addr = AW'(DEPTH_C - right_r);
      CMD_READ: begin
        if (idx_x < left_x) begin
          rd_addr = AW'(idx_x);
        end else begin
          rd_addr = AW'(XW'(DEPTH) - right_x + idx_x - left_x);
        end
      end
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    left_nxt    = left_r;
    right_nxt   = right_r;
    we          = 1'b0;
    wr_addr     = AW'(left_r);
    wr_data     = char_r;
    chr_nxt     = '0;
    dropped_nxt = 1'b0;
    oor_nxt     = 1'b0;
    unique case (cmd_r)
      CMD_LEFT: begin
        if (left_r != '0) begin
          we        = 1'b1;
          wr_addr   = AW'(DEPTH_C - right_r - CW'(1));
          wr_data   = rd_data;
          left_nxt  = left_r - CW'(1);
          right_nxt = right_r + CW'(1);
        end
      end
      CMD_RIGHT: begin
        if (right_r != '0) begin
          we        = 1'b1;
          wr_data   = rd_data;
          left_nxt  = left_r + CW'(1);
          right_nxt = right_r - CW'(1);
        end
      end
      CMD_BACK: begin
        if (left_r != '0) begin
          left_nxt = left_r - CW'(1);
        end
      end
      CMD_INSERT: begin
        if (len < DEPTH_C) begin
          we       = 1'b1;
          left_nxt = left_r + CW'(1);
        end else begin
          dropped_nxt = 1'b1;
        end
      end
      CMD_READ: begin
        if (XW'(idx_r) < XW'(len)) begin
          chr_nxt = rd_data;
        end else begin
          oor_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  ctb_text_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (we && adv),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (accept),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      right_r <= '0;
    end else if (adv) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      char_out_r    <= chr_nxt;
      text_length_r <= LEN_W'(left_nxt + right_nxt);
      cursor_pos_r  <= LEN_W'(left_nxt);
      dropped_r     <= dropped_nxt;
      oor_r         <= oor_nxt;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.char_out          = char_out_r;
  assign out_chan.text_length       = text_length_r;
  assign out_chan.cursor_pos        = cursor_pos_r;
  assign out_chan.insert_dropped    = dropped_r;
  assign out_chan.read_out_of_range = oor_r;

endmodule

// ===== design/ctb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctb_checker: port-level checks of the cursor text buffer
// Watches the command and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module ctb_checker import ctb_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [CHAR_W-1:0] out_char,
  input logic [LEN_W-1:0] out_length,
  input logic [LEN_W-1:0] out_cursor,
  input logic             out_dropped,
  input logic             out_oor
);

  localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(DEPTH);

  // A result beat that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn before it was taken");

  // The block works on one command at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command accepted while the previous one is in flight");

  // The cursor never lies beyond the end of the text.
  a_cursor_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cursor <= out_length)
    else $error("cursor beyond end of text");

  // A dropped insert only happens on a full buffer and flags nothing else.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> out_length == DEPTH_L && !out_oor && out_char == '0)
    else $error("insert dropped on a buffer that is not full");

  // An out-of-range read returns no character.
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_oor |-> out_char == '0)
    else $error("out-of-range read returned a character");

endmodule

bind cursor_text_buffer ctb_checker #(.DEPTH(DEPTH)) u_ctb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_char   (out_chan.char_out),
  .out_length (out_chan.text_length),
  .out_cursor (out_chan.cursor_pos),
  .out_dropped(out_chan.insert_dropped),
  .out_oor    (out_chan.read_out_of_range)
);
